// File: rtl/dtq_pkg.sv
package dtq_pkg;
  localparam int DefaultDepth = 16;
  localparam int TimeW = 48;
  localparam int WordW = 32;

  localparam logic [1:0] CmdSchedule = 2'd0;
  localparam logic [1:0] CmdCancel   = 2'd1;
  localparam logic [1:0] CmdTick     = 2'd2;
  localparam logic [1:0] CmdShutdown = 2'd3;

  localparam logic [2:0] KindScheduled   = 3'd0;
  localparam logic [2:0] KindRejShutdown = 3'd1;
  localparam logic [2:0] KindRejFull     = 3'd2;
  localparam logic [2:0] KindCancelAck   = 3'd3;
  localparam logic [2:0] KindDispatched  = 3'd4;
  localparam logic [2:0] KindNoneDue     = 3'd5;
  localparam logic [2:0] KindShutdownAck = 3'd6;

  typedef struct packed {
    logic [1:0]       command;
    logic [WordW-1:0] delay_ticks;
    logic [WordW-1:0] task_tag;
    logic [WordW-1:0] cancel_handle;
  } cmd_t;
endpackage

// File: rtl/dtq_cmd_fifo.sv
module dtq_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  dtq_pkg::cmd_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output dtq_pkg::cmd_t pop_data_o
);
  import dtq_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o     = cnt_q == 2'd2;
  assign empty_o    = cnt_q == 2'd0;
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0; rd_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push_i && !full_o) wr_q <= ~wr_q;
      if (pop_i && !empty_o) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i && !full_o} - {1'b0, pop_i && !empty_o};
    end
  end
endmodule

// File: rtl/dtq_engine.sv
module dtq_engine #(
  parameter int QueueDepth = dtq_pkg::DefaultDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  dtq_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  output logic          result_valid_o,
  input  logic          result_ready_i,
  output logic [2:0]    result_kind_o,
  output logic [31:0]   handle_o,
  output logic [31:0]   dispatched_tag_o,
  output logic          last_o
);
  import dtq_pkg::*;
  localparam int IdxW = $clog2(QueueDepth);

  typedef enum logic [2:0] {Idle, CancelScan, Scan, Pick, Emit, Flush} state_e;

  state_e state_q;
  logic [TimeW-1:0] due_q [QueueDepth];
  logic [WordW-1:0] seq_q [QueueDepth];
  logic [WordW-1:0] tag_q [QueueDepth];
  logic [QueueDepth-1:0] valid_q, canc_q;
  logic [TimeW-1:0] now_q;
  logic [WordW-1:0] next_q;
  logic             shut_q;
  logic [IdxW-1:0]  idx_q;
  logic             found_q;
  logic [IdxW-1:0]  best_q;
  logic [TimeW-1:0] best_due_q;
  logic [WordW-1:0] best_seq_q;
  cmd_t             cur_q;
  // Output holding register with one pending dispatch buffered behind it.
  logic             ov_q;
  logic [2:0]       ok_q;
  logic [WordW-1:0] oh_q, ot_q;
  logic             ol_q;
  logic             pv_q;
  logic [WordW-1:0] ph_q, pt_q;

  logic [IdxW-1:0] free_idx;
  logic            free_ok;
  always_comb begin
    free_idx = '0; free_ok = 1'b0;
    for (int i = QueueDepth - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin free_idx = IdxW'(i); free_ok = 1'b1; end
    end
  end

  logic out_free;
  assign out_free = !ov_q || result_ready_i;
  assign cmd_pop_o = state_q == Idle && cmd_valid_i && out_free && !pv_q;
  assign result_valid_o = ov_q;
  assign result_kind_o = ok_q;
  assign handle_o = oh_q;
  assign dispatched_tag_o = ot_q;
  assign last_o = ol_q;

  logic cand_ok, better;
  assign cand_ok = valid_q[idx_q] && due_q[idx_q] <= now_q;
  assign better = !found_q || due_q[idx_q] < best_due_q ||
                  (due_q[idx_q] == best_due_q && seq_q[idx_q] < best_seq_q);

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o && cmd_i.command == CmdSchedule && !shut_q && free_ok) begin
      due_q[free_idx] <= now_q + TimeW'(cmd_i.delay_ticks);
      seq_q[free_idx] <= next_q;
      tag_q[free_idx] <= cmd_i.task_tag;
    end
    if (cmd_pop_o) cur_q <= cmd_i;
    if (state_q == Scan && cand_ok && better) begin
      best_q <= idx_q; best_due_q <= due_q[idx_q]; best_seq_q <= seq_q[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Idle; valid_q <= '0; canc_q <= '0; now_q <= '0; next_q <= '0;
      shut_q <= 1'b0; idx_q <= '0; found_q <= 1'b0;
      ov_q <= 1'b0; ok_q <= '0; oh_q <= '0; ot_q <= '0; ol_q <= 1'b0;
      pv_q <= 1'b0; ph_q <= '0; pt_q <= '0;
    end else begin
      if (ov_q && result_ready_i) ov_q <= 1'b0;
      case (state_q)
        Idle: begin
          if (cmd_pop_o) begin
            ov_q <= 1'b1; ol_q <= 1'b1; oh_q <= '0; ot_q <= '0;
            case (cmd_i.command)
              CmdSchedule: begin
                if (shut_q) ok_q <= KindRejShutdown;
                else if (!free_ok) ok_q <= KindRejFull;
                else begin
                  ok_q <= KindScheduled; oh_q <= next_q;
                  valid_q[free_idx] <= 1'b1; canc_q[free_idx] <= 1'b0;
                  next_q <= next_q + 1'b1;
                end
              end
              CmdCancel: begin
                ov_q <= 1'b0; idx_q <= '0; state_q <= CancelScan;
              end
              CmdTick: begin
                ov_q <= 1'b0; now_q <= now_q + 1'b1; idx_q <= '0;
                found_q <= 1'b0; state_q <= Scan;
              end
              default: begin
                ok_q <= KindShutdownAck; valid_q <= '0; canc_q <= '0;
                shut_q <= 1'b1;
              end
            endcase
          end
        end
        CancelScan: begin
          if (valid_q[idx_q] && seq_q[idx_q] == cur_q.cancel_handle)
            canc_q[idx_q] <= 1'b1;
          if (idx_q == IdxW'(QueueDepth - 1)) begin
            if (out_free) begin
              ov_q <= 1'b1; ok_q <= KindCancelAck; oh_q <= cur_q.cancel_handle;
              ot_q <= '0; ol_q <= 1'b1; state_q <= Idle;
            end
          end else idx_q <= idx_q + 1'b1;
        end
        Scan: begin
          if (cand_ok) found_q <= 1'b1;
          if (idx_q == IdxW'(QueueDepth - 1)) state_q <= Pick;
          else idx_q <= idx_q + 1'b1;
        end
        Pick: begin
          if (found_q) begin
            valid_q[best_q] <= 1'b0;
            if (!canc_q[best_q]) state_q <= Emit;
            else begin idx_q <= '0; found_q <= 1'b0; state_q <= Scan; end
          end else state_q <= Flush;
        end
        Emit: begin
          // Hold the dispatch until the next scan tells whether it is last.
          if (!pv_q || out_free) begin
            if (pv_q) begin
              ov_q <= 1'b1; ok_q <= KindDispatched; oh_q <= ph_q; ot_q <= pt_q;
              ol_q <= 1'b0;
            end
            pv_q <= 1'b1; ph_q <= best_seq_q; pt_q <= tag_q[best_q];
            idx_q <= '0; found_q <= 1'b0; state_q <= Scan;
          end
        end
        Flush: begin
          if (out_free) begin
            ov_q <= 1'b1; ol_q <= 1'b1;
            if (pv_q) begin ok_q <= KindDispatched; oh_q <= ph_q; ot_q <= pt_q; end
            else begin ok_q <= KindNoneDue; oh_q <= '0; ot_q <= '0; end
            pv_q <= 1'b0; state_q <= Idle;
          end
        end
        default: state_q <= Idle;
      endcase
    end
  end
endmodule

// File: rtl/deadline_timer_queue_unit.sv
// A schedule or shutdown result is registered in the engine once the command is accepted;
// a cancel result follows a serial walk over all the slots. A tick runs a serial scan of
// the slots for the earliest due entry, then a fresh scan after each dispatched entry and
// after each cancelled entry that is dropped; output stalls add to this.
// Throughput: one command at a time in the engine; a two-entry queue takes commands
// while it works. Reset is asynchronous, active low, and empties the queue at once.
module deadline_timer_queue_unit #(
  parameter int QUEUE_DEPTH = dtq_pkg::DefaultDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [31:0] delay_ticks_i,
  input  logic [31:0] task_tag_i,
  input  logic [31:0] cancel_handle_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  result_kind_o,
  output logic [31:0] handle_o,
  output logic [31:0] dispatched_tag_o,
  output logic        last_o
);
  import dtq_pkg::*;

  cmd_t in_cmd, q_cmd;
  logic full, empty, pop;
  assign in_cmd = '{command: command_i, delay_ticks: delay_ticks_i,
                    task_tag: task_tag_i, cancel_handle: cancel_handle_i};
  assign in_ready_o = !full;

  dtq_cmd_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(in_valid_i), .push_data_i(in_cmd), .full_o(full),
    .pop_i(pop), .empty_o(empty), .pop_data_o(q_cmd)
  );

  dtq_engine #(.QueueDepth(QUEUE_DEPTH)) u_engine (
    .clk_i, .rst_ni, .cmd_valid_i(!empty), .cmd_i(q_cmd), .cmd_pop_o(pop),
    .result_valid_o(out_valid_o), .result_ready_i(out_ready_i),
    .result_kind_o, .handle_o, .dispatched_tag_o, .last_o
  );

`ifndef SYNTHESIS
  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> result_kind_o != 3'd7) else $error("bad result kind");
  a_last_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o != KindDispatched |-> last_o)
    else $error("non-dispatch result without last");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty) else $error("pop from empty queue");
`endif
endmodule
